// ===== rtl/tab_pkg.sv =====
package tab_pkg;

  localparam int MAX_TRIANGLES_DEF = 4096;
  localparam int VERTEX_BITS_DEF   = 16;
  localparam int EDGE_SLOTS_DEF    = 16384;

  localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;
  localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_ADDED = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] vert_a;
    logic [15:0] vert_b;
    logic [15:0] vert_c;
    logic [11:0] tri_index;
  } req_word_t;

  typedef struct packed {
    logic [15:0] index_value;
    logic [1:0]  status;
    logic        is_last;
  } rsp_word_t;

endpackage

// ===== rtl/tab_ram.sv =====
module tab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/tab_hash.sv =====
module tab_hash #(
  parameter int VB = 16,
  parameter int N = 16384,
  localparam int SB = $clog2(N)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [VB-1:0] key_hi,
  input  logic [VB-1:0] key_lo,
  output logic          done,
  output logic [SB-1:0] slot
);
  import tab_pkg::*;

  localparam bit POW2 = ((N & (N - 1)) == 0);

  localparam logic [63:0] R32_W    = 64'h1_0000_0000 % 64'(N);
  localparam logic [63:0] RCP_W    = 64'h1_0000_0000 / 64'(N);
  localparam logic [31:0] FOLD_MUL = R32_W[31:0];
  localparam logic [31:0] RCP_MUL  = RCP_W[31:0];
  localparam logic [31:0] N_W      = 32'(N);

  localparam logic [3:0] P_IDLE = 4'd0;
  localparam logic [3:0] P_M0   = 4'd1;
  localparam logic [3:0] P_M1   = 4'd2;
  localparam logic [3:0] P_M2   = 4'd3;
  localparam logic [3:0] P_MIX  = 4'd4;
  localparam logic [3:0] P_FOLD = 4'd5;
  localparam logic [3:0] P_QUO  = 4'd6;
  localparam logic [3:0] P_REM  = 4'd7;
  localparam logic [3:0] P_FIX  = 4'd8;

  logic [3:0]  ph;
  logic [31:0] ka, kb;
  logic [63:0] acc;
  logic [31:0] quo;
  logic [31:0] rm;
  logic [31:0] mul_x, mul_y;
  logic [63:0] prod;
  logic [63:0] mixed;

  always_comb begin
    case (ph)
      P_M1: begin
        mul_x = kb;
        mul_y = HASH_MUL_HI;
      end
      P_M2: begin
        mul_x = ka;
        mul_y = HASH_MUL_LO;
      end
      P_FOLD: begin
        mul_x = acc[63:32];
        mul_y = FOLD_MUL;
      end
      P_QUO: begin
        mul_x = acc[31:0];
        mul_y = RCP_MUL;
      end
      P_REM: begin
        mul_x = quo;
        mul_y = N_W;
      end
      default: begin
        mul_x = kb;
        mul_y = HASH_MUL_LO;
      end
    endcase
  end

  assign prod  = 64'(mul_x) * 64'(mul_y);
  assign mixed = acc ^ (acc >> 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= P_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ph)
        P_IDLE: begin
          if (start) begin
            ka <= 32'(key_hi);
            kb <= 32'(key_lo);
            ph <= P_M0;
          end
        end
        P_M0: begin
          acc <= prod;
          ph  <= P_M1;
        end
        P_M1: begin
          acc[63:32] <= acc[63:32] + prod[31:0];
          ph         <= P_M2;
        end
        P_M2: begin
          acc[63:32] <= acc[63:32] + prod[31:0];
          ph         <= P_MIX;
        end
        P_MIX: begin
          acc <= mixed;
          if (POW2) begin
            slot <= mixed[SB-1:0];
            done <= 1'b1;
            ph   <= P_IDLE;
          end else begin
            ph <= P_FOLD;
          end
        end
        P_FOLD: begin
          if (acc[63:32] == 32'd0) begin
            ph <= P_QUO;
          end else begin
            acc <= prod + {32'd0, acc[31:0]};
          end
        end
        P_QUO: begin
          quo <= prod[63:32];
          ph  <= P_REM;
        end
        P_REM: begin
          rm <= acc[31:0] - prod[31:0];
          ph <= P_FIX;
        end
        P_FIX: begin
          slot <= (rm >= N_W) ? SB'(rm - N_W) : rm[SB-1:0];
          done <= 1'b1;
          ph   <= P_IDLE;
        end
        default: ph <= P_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/triangle_adjacency_builder.sv =====
// Add: one status word; query: six words (each corner, then the vertex across its edge),
//   or one word for an out-of-range index; an add when the triangle store is full: one word.
// Clear: one word once every edge slot is marked empty. A new request is taken only after
//   the last word of the one before; a lookup probes edge slots in turn, and the hash takes
//   extra steps when EDGE_SLOTS is not a power of two. Reset (rst, synchronous) starts a
//   pass that marks every edge slot empty; req_stall stays high until it ends.
module triangle_adjacency_builder #(
  parameter int MAX_TRIANGLES = tab_pkg::MAX_TRIANGLES_DEF,
  parameter int VERTEX_BITS   = tab_pkg::VERTEX_BITS_DEF,
  parameter int EDGE_SLOTS    = tab_pkg::EDGE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  tab_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output tab_pkg::rsp_word_t rsp
);
  import tab_pkg::*;

  localparam int VB  = VERTEX_BITS;
  localparam int N   = EDGE_SLOTS;
  localparam int SB  = $clog2(N);
  localparam int EW  = 1 + 3 * VB;
  localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CW  = $clog2(MAX_TRIANGLES + 1);
  localparam int UW  = $clog2(N + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SWEEP = 4'd1;
  localparam logic [3:0] S_NEXTE = 4'd2;
  localparam logic [3:0] S_HASH  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_TRD   = 4'd6;
  localparam logic [3:0] S_QV    = 4'd7;
  localparam logic [3:0] S_QF    = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  localparam logic [1:0] M_CHECK  = 2'd0;
  localparam logic [1:0] M_COMMIT = 2'd1;
  localparam logic [1:0] M_QUERY  = 2'd2;

  function automatic logic [1:0] nx(input logic [1:0] i);
    case (i)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] pv(input logic [1:0] i);
    case (i)
      2'd0:    return 2'd2;
      2'd1:    return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

  function automatic logic [15:0] to16(input logic [VB-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[15:0];
  endfunction

  logic [3:0]    state, ret;
  logic [1:0]    mode, idx, needed;
  logic [VB-1:0] v [3];
  logic [SB-1:0] sweep, slot;
  logic [SB:0]   pc;
  logic          clr_emit;
  logic [CW-1:0] count;
  logic [UW-1:0] used;
  logic [15:0]   res_value;
  logic [1:0]    res_status;
  logic          res_last;

  logic [VB-1:0] vsel, key_hi, key_lo, third;
  logic [31:0]   a32, b32, c32, t32;
  logic          dup1, dup2, dup_sel, over, emit_load, h_start, h_done;
  logic [SB-1:0] h_slot;
  logic          e_we, e_valid, key_match;
  logic [SB-1:0] e_addr;
  logic [EW-1:0] e_wdata, e_rdata;
  logic          t_we;
  logic [TAW-1:0] t_addr;
  logic [3*VB-1:0] t_rdata;

  assign a32 = 32'(req.vert_a);
  assign b32 = 32'(req.vert_b);
  assign c32 = 32'(req.vert_c);
  assign t32 = 32'(req.tri_index);

  always_comb begin
    case (idx)
      2'd0:    vsel = v[0];
      2'd1:    vsel = v[1];
      default: vsel = v[2];
    endcase
  end

  assign key_hi = (mode == M_QUERY) ? v[nx(idx)] : vsel;
  assign key_lo = (mode == M_QUERY) ? vsel : v[nx(idx)];
  assign third  = v[pv(idx)];

  assign dup1 = (v[1] == v[0]) && (v[2] == v[1]);
  assign dup2 = ((v[2] == v[0]) && (v[0] == v[1])) || ((v[2] == v[1]) && (v[0] == v[2]));
  assign dup_sel = (idx == 2'd1) ? dup1 : ((idx == 2'd2) ? dup2 : 1'b0);
  assign over = (32'(used) + 32'(needed)) > 32'(N);

  assign h_start = ((state == S_NEXTE) && (idx != 2'd3) && !((mode == M_CHECK) && dup_sel))
                   || (state == S_QF);

  assign e_valid   = e_rdata[EW-1];
  assign key_match = (e_rdata[3*VB-1:2*VB] == key_hi) && (e_rdata[2*VB-1:VB] == key_lo);

  always_comb begin
    e_we    = 1'b0;
    e_addr  = slot;
    e_wdata = {1'b1, key_hi, key_lo, third};
    if (state == S_SWEEP) begin
      e_we    = 1'b1;
      e_addr  = sweep;
      e_wdata = '0;
    end else if ((state == S_CHK) && (mode == M_COMMIT) && !e_valid) begin
      e_we = 1'b1;
    end
  end

  assign t_we   = (state == S_NEXTE) && (idx == 2'd3) && (mode == M_CHECK) && !over;
  assign t_addr = t_we ? count[TAW-1:0] : t32[TAW-1:0];

  assign req_stall = (state != S_IDLE);
  assign emit_load = (state == S_EMIT) && (!rsp_valid || !rsp_stall);

  tab_hash #(.VB(VB), .N(N)) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (h_start),
    .key_hi (key_hi),
    .key_lo (key_lo),
    .done   (h_done),
    .slot   (h_slot)
  );

  tab_ram #(.WIDTH(EW), .DEPTH(N)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .addr  (e_addr),
    .wdata (e_wdata),
    .rdata (e_rdata)
  );

  tab_ram #(.WIDTH(3*VB), .DEPTH(MAX_TRIANGLES)) u_tri_ram (
    .clk   (clk),
    .we    (t_we),
    .addr  (t_addr),
    .wdata ({v[0], v[1], v[2]}),
    .rdata (t_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_load) begin
      rsp_valid       <= 1'b1;
      rsp.index_value <= res_value;
      rsp.status      <= res_status;
      rsp.is_last     <= res_last;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_SWEEP;
      sweep    <= '0;
      clr_emit <= 1'b0;
      count    <= '0;
      used     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            v[0]       <= a32[VB-1:0];
            v[1]       <= b32[VB-1:0];
            v[2]       <= c32[VB-1:0];
            res_value  <= '0;
            res_last   <= 1'b1;
            res_status <= ST_OK;
            ret        <= S_IDLE;
            case (req.req_type)
              REQ_ADD: begin
                if (32'(count) >= 32'(MAX_TRIANGLES)) begin
                  res_status <= ST_FULL;
                  state      <= S_EMIT;
                end else begin
                  mode   <= M_CHECK;
                  idx    <= 2'd0;
                  needed <= 2'd0;
                  state  <= S_NEXTE;
                end
              end
              REQ_QUERY: begin
                if (t32 >= 32'(count)) begin
                  res_status <= ST_NOT_ADDED;
                  state      <= S_EMIT;
                end else begin
                  state <= S_TRD;
                end
              end
              REQ_CLEAR: begin
                sweep    <= '0;
                clr_emit <= 1'b1;
                state    <= S_SWEEP;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SWEEP: begin
          if (sweep == SB'(N - 1)) begin
            if (clr_emit) begin
              count      <= '0;
              used       <= '0;
              res_value  <= '0;
              res_status <= ST_OK;
              res_last   <= 1'b1;
              ret        <= S_IDLE;
              state      <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            sweep <= sweep + SB'(1);
          end
        end
        S_NEXTE: begin
          if (idx == 2'd3) begin
            if ((mode == M_CHECK) && over) begin
              res_status <= ST_FULL;
              state      <= S_EMIT;
            end else if (mode == M_CHECK) begin
              count <= count + CW'(1);
              mode  <= M_COMMIT;
              idx   <= 2'd0;
            end else begin
              state <= S_EMIT;
            end
          end else if ((mode == M_CHECK) && dup_sel) begin
            idx <= idx + 2'd1;
          end else begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (h_done) begin
            slot  <= h_slot;
            pc    <= '0;
            state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (!e_valid || key_match || (pc == (SB+1)'(N - 1))) begin
            idx <= idx + 2'd1;
            case (mode)
              M_CHECK: begin
                if (!(e_valid && key_match)) begin
                  needed <= needed + 2'd1;
                end
                state <= S_NEXTE;
              end
              M_COMMIT: begin
                if (!e_valid) begin
                  used <= used + UW'(1);
                end
                state <= S_NEXTE;
              end
              default: begin
                res_value  <= to16((e_valid && key_match) ? e_rdata[VB-1:0] : third);
                res_status <= ST_OK;
                res_last   <= (idx == 2'd2);
                ret        <= (idx == 2'd2) ? S_IDLE : S_QV;
                state      <= S_EMIT;
              end
            endcase
          end else begin
            slot  <= (slot == SB'(N - 1)) ? '0 : slot + SB'(1);
            pc    <= pc + (SB+1)'(1);
            state <= S_RD;
          end
        end
        S_TRD: begin
          v[0]  <= t_rdata[3*VB-1:2*VB];
          v[1]  <= t_rdata[2*VB-1:VB];
          v[2]  <= t_rdata[VB-1:0];
          idx   <= 2'd0;
          mode  <= M_QUERY;
          state <= S_QV;
        end
        S_QV: begin
          res_value  <= to16(vsel);
          res_status <= ST_OK;
          res_last   <= 1'b0;
          ret        <= S_QF;
          state      <= S_EMIT;
        end
        S_QF: state <= S_HASH;
        S_EMIT: begin
          if (emit_load) begin
            state <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tab_checker.sv =====
module tab_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input tab_pkg::req_word_t req,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input tab_pkg::rsp_word_t rsp
);
  import tab_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled rsp word changed");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled req word changed");

  a_reset_stall: assert property (@(posedge clk) rst |=> req_stall)
    else $error("req taken during reset sweep");

  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> rsp.is_last && (rsp.index_value == 16'd0))
    else $error("status word not a single zero word");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status <= ST_NOT_ADDED))
    else $error("bad status code");

endmodule

bind triangle_adjacency_builder tab_checker u_tab_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tab_pkg::*;

  localparam int MAX_TRI = MAX_TRIANGLES_DEF;
  localparam int SLOTS = EDGE_SLOTS_DEF;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_word_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_word_t rsp;

  triangle_adjacency_builder DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  req_word_t pending_reqs[$];
  rsp_word_t expected_words[$];

  logic [15:0] tri_corners[MAX_TRI][3];
  int unsigned tri_count;
  logic [31:0] slot_key[SLOTS];
  logic [15:0] slot_third[SLOTS];
  bit slot_used[SLOTS];
  int unsigned slots_taken;

  int errors;
  int mismatches;
  longint cycles;
  bit stim_done;
  int burst_left;
  int gap_left;
  int hold_left;
  bit hold_requested;
  logic [15:0] pool[8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int hash_slot(logic [31:0] key);
    logic [63:0] h;
    h = {16'd0, key[31:16], 16'd0, key[15:0]} * {HASH_MUL_HI, HASH_MUL_LO};
    h = h ^ (h >> 29);
    return int'(h % SLOTS);
  endfunction

  function automatic int lookup_edge(logic [31:0] key);
    int s;
    s = hash_slot(key);
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_used[s]) return -1;
      if (slot_key[s] == key) return s;
      s = (s + 1 == SLOTS) ? 0 : s + 1;
    end
    return -1;
  endfunction

  function automatic void store_edge(logic [31:0] key, logic [15:0] third);
    int s;
    if (lookup_edge(key) >= 0) return;
    s = hash_slot(key);
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_used[s]) begin
        slot_used[s] = 1'b1;
        slot_key[s] = key;
        slot_third[s] = third;
        slots_taken++;
        return;
      end
      s = (s + 1 == SLOTS) ? 0 : s + 1;
    end
  endfunction

  function automatic logic [15:0] neighbor_vertex(logic [15:0] a, logic [15:0] b,
                                                  logic [15:0] fallback);
    int s;
    s = lookup_edge({b, a});
    return (s < 0) ? fallback : slot_third[s];
  endfunction

  function automatic void push_word(logic [15:0] v, logic [1:0] st, logic last);
    rsp_word_t w;
    w.index_value = v;
    w.status = st;
    w.is_last = last;
    expected_words = {expected_words, w};
  endfunction

  function automatic void add_pending(req_word_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void predict_adjacency(req_word_t r);
    logic [31:0] keys[3];
    logic [15:0] thirds[3];
    logic [15:0] v0, v1, v2;
    int needed;
    bit dup;
    case (r.req_type)
      REQ_ADD: begin
        keys[0] = {r.vert_a, r.vert_b}; thirds[0] = r.vert_c;
        keys[1] = {r.vert_b, r.vert_c}; thirds[1] = r.vert_a;
        keys[2] = {r.vert_c, r.vert_a}; thirds[2] = r.vert_b;
        needed = 0;
        for (int i = 0; i < 3; i++) begin
          dup = 1'b0;
          for (int j = 0; j < i; j++) if (keys[j] == keys[i]) dup = 1'b1;
          if (!dup && lookup_edge(keys[i]) < 0) needed++;
        end
        if (tri_count >= MAX_TRI || slots_taken + needed > SLOTS) begin
          push_word(16'd0, ST_FULL, 1'b1);
        end else begin
          tri_corners[tri_count][0] = r.vert_a;
          tri_corners[tri_count][1] = r.vert_b;
          tri_corners[tri_count][2] = r.vert_c;
          tri_count++;
          for (int i = 0; i < 3; i++) store_edge(keys[i], thirds[i]);
          push_word(16'd0, ST_OK, 1'b1);
        end
      end
      REQ_QUERY: begin
        if (r.tri_index >= tri_count) begin
          push_word(16'd0, ST_NOT_ADDED, 1'b1);
        end else begin
          v0 = tri_corners[r.tri_index][0];
          v1 = tri_corners[r.tri_index][1];
          v2 = tri_corners[r.tri_index][2];
          push_word(v0, ST_OK, 1'b0);
          push_word(neighbor_vertex(v0, v1, v2), ST_OK, 1'b0);
          push_word(v1, ST_OK, 1'b0);
          push_word(neighbor_vertex(v1, v2, v0), ST_OK, 1'b0);
          push_word(v2, ST_OK, 1'b0);
          push_word(neighbor_vertex(v2, v0, v1), ST_OK, 1'b1);
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
        tri_count = 0;
        slots_taken = 0;
        push_word(16'd0, ST_OK, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic req_word_t make_req(logic [1:0] kind, logic [15:0] a, logic [15:0] b,
                                         logic [15:0] c, logic [11:0] t);
    req_word_t r;
    r.req_type = kind;
    r.vert_a = a;
    r.vert_b = b;
    r.vert_c = c;
    r.tri_index = t;
    return r;
  endfunction

  function automatic logic [15:0] pick_vertex();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return pool[$urandom_range(0, 7)];
  endfunction

  // shared vertices make adjacent triangles; random indices hit both valid and out-of-range
  function automatic void queue_mesh(int n_tri, int n_query);
    logic [15:0] a, b, c;
    for (int i = 0; i < 8; i++) pool[i] = 16'($urandom);
    for (int i = 0; i < n_tri; i++) begin
      a = pick_vertex();
      b = pick_vertex();
      c = pick_vertex();
      if ($urandom_range(0, 1)) add_pending(make_req(REQ_ADD, a, b, c, 12'($urandom)));
      else add_pending(make_req(REQ_ADD, b, a, c, 12'($urandom)));
      if ($urandom_range(0, 2) == 0)
        add_pending(make_req(REQ_QUERY, 16'($urandom), 16'($urandom),
                             16'($urandom), 12'($urandom_range(0, n_tri + 2))));
    end
    for (int i = 0; i < n_query; i++)
      add_pending(make_req(REQ_QUERY, 16'($urandom), 16'($urandom),
                           16'($urandom), 12'($urandom_range(0, n_tri + 2))));
  endfunction

  initial begin
    rst = 1'b1;
    errors = 0;
    mismatches = 0;
    tri_count = 0;
    slots_taken = 0;
    stim_done = 1'b0;
    hold_requested = 1'b0;
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;

    add_pending(make_req(REQ_QUERY, 16'd0, 16'd0, 16'd0, 12'd0));
    add_pending(make_req(REQ_ADD, 16'd0, 16'd1, 16'd2, 12'hFFF));
    add_pending(make_req(REQ_ADD, 16'd1, 16'd0, 16'hFFFF, 12'd0));
    add_pending(make_req(REQ_ADD, 16'd2, 16'd1, 16'hFFFF, 12'd0));
    add_pending(make_req(REQ_ADD, 16'd0, 16'd1, 16'd7, 12'd0));
    add_pending(make_req(REQ_ADD, 16'h5, 16'h5, 16'h5, 12'd0));
    add_pending(make_req(REQ_ADD, 16'h8, 16'h8, 16'h9, 12'd0));
    add_pending(make_req(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF));
    for (int i = 0; i < 6; i++)
      add_pending(make_req(REQ_QUERY, 16'hAAAA, 16'h5555, 16'hFFFF, 12'(i)));
    add_pending(make_req(REQ_QUERY, 16'd0, 16'd0, 16'd0, 12'd6));
    add_pending(make_req(REQ_QUERY, 16'd0, 16'd0, 16'd0, 12'hFFF));
    add_pending(make_req(REQ_CLEAR, 16'h1234, 16'h5678, 16'h9ABC, 12'h555));
    add_pending(make_req(REQ_QUERY, 16'd0, 16'd0, 16'd0, 12'd0));
    add_pending(make_req(REQ_ADD, 16'hFFFF, 16'hFFFE, 16'hFFFD, 12'hAAA));
    add_pending(make_req(REQ_QUERY, 16'd0, 16'd0, 16'd0, 12'd0));

    for (int k = 0; k < 5; k++) begin
      queue_mesh($urandom_range(15, 40), $urandom_range(10, 20));
      if ($urandom_range(0, 3) == 0)
        add_pending(make_req(2'd3, 16'($urandom), 16'($urandom),
                             16'($urandom), 12'($urandom)));
      add_pending(make_req(REQ_CLEAR, 16'($urandom), 16'($urandom),
                           16'($urandom), 12'($urandom)));
    end
    queue_mesh(30, 15);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0 && !req_valid);
    stim_done = 1'b1;
  end

  // sender: bursts and gaps; payload holds while stalled
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
      burst_left <= $urandom_range(1, 12);
      gap_left <= 0;
    end else begin
      if (req_valid && !req_stall) predict_adjacency(req);
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off once fewer than 200 requests are pending
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (!hold_requested && pending_reqs.size() < 200) begin
      hold_requested <= 1'b1;
      hold_left <= 400;
      rsp_stall <= 1'b1;
    end else if (cycles % 2000 < 700) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected word: %h", rsp);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (rsp !== want) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch: expected value %h status %0d last %0b, got %h %0d %0b",
                     want.index_value, want.status, want.is_last,
                     rsp.index_value, rsp.status, rsp.is_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (expected_words.size() == 0);
    repeat (SLOTS + 200) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tab_pkg.sv
rtl/tab_ram.sv
rtl/tab_hash.sv
rtl/triangle_adjacency_builder.sv
rtl/tab_checker.sv
tb/sv/tb_top.sv
